/* rtl/mtp_pkg.sv */
package mtp_pkg;

  localparam int unsigned IdW    = 4;
  localparam int unsigned DurW   = 16;
  localparam int unsigned TickW  = 16;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned OpW    = 2;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef struct packed {
    op_e             operation;
    logic [IdW-1:0]  timer_id;
    logic [DurW-1:0] duration_ms;
  } item_t;

  typedef struct packed {
    logic             addressed_expired;
    logic [MaskW-1:0] expired_mask;
  } result_t;

endpackage

/* rtl/mtp_timer_bank.sv */
module mtp_timer_bank #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  mtp_pkg::item_t              item_i,
  input  logic [mtp_pkg::ShiftW-1:0]  tick_shift_i,
  output mtp_pkg::result_t            result_o
);
  import mtp_pkg::*;

  logic [TickW-1:0]      rem_q [NUM_TIMERS];
  logic [TickW-1:0]      rem_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] run_q;
  logic [NUM_TIMERS-1:0] run_d;
  logic [NUM_TIMERS-1:0] exp_v;
  logic [NUM_TIMERS-1:0] zero_v;
  logic [NUM_TIMERS-1:0] hit_v;
  logic                  any_zero;
  logic [TickW-1:0]      start_ticks;
  logic [MaskW-1:0]      mask;
  logic [MaskW-1:0]      addr_run;

  assign any_zero    = |(run_q & zero_v);
  assign start_ticks = TickW'(item_i.duration_ms >> tick_shift_i);

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_lane
    assign zero_v[i] = (rem_q[i] == '0);

    if (i < MaskW) begin : g_addr
      assign hit_v[i] = (item_i.timer_id == IdW'(i));
    end else begin : g_noaddr
      assign hit_v[i] = 1'b0;
    end

    always_comb begin
      rem_d[i] = rem_q[i];
      run_d[i] = run_q[i];
      exp_v[i] = 1'b0;
      unique case (item_i.operation)
        OP_TICK: begin
          if (run_q[i]) begin
            if (!any_zero) begin
              rem_d[i] = rem_q[i] - TickW'(1);
            end
            exp_v[i] = any_zero ? zero_v[i] : (rem_q[i] == TickW'(1));
            if (exp_v[i]) begin
              run_d[i] = 1'b0;
            end
          end
        end
        OP_START: begin
          if (hit_v[i]) begin
            rem_d[i] = start_ticks;
            run_d[i] = (item_i.duration_ms != '0);
          end
        end
        OP_STOP: begin
          if (hit_v[i]) begin
            run_d[i] = 1'b0;
          end
        end
        OP_QUERY: begin
        end
        default: begin
        end
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[i] <= '0;
      end else if (en_i) begin
        rem_q[i] <= rem_d[i];
      end
    end
  end

  for (genvar j = 0; j < MaskW; j++) begin : g_view
    if (j < NUM_TIMERS) begin : g_on
      assign mask[j]     = exp_v[j];
      assign addr_run[j] = run_d[j];
    end else begin : g_off
      assign mask[j]     = 1'b0;
      assign addr_run[j] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (en_i) begin
      run_q <= run_d;
    end
  end

  assign result_o.addressed_expired = ~addr_run[item_i.timer_id];
  assign result_o.expired_mask      = mask;

endmodule

/* rtl/multi_timer_pool.sv */
// Channel  | Direction | tdata (low bit up)                    | tuser
// s_axis   | in        | timer_id[3:0], duration_ms[19:4]      | operation[1:0]
// m_axis   | out       | addressed_expired[0], expired_mask[16:1] | -
// cfg      | in        | cfg_wdata_i = tick_shift              | -
//
// One item is accepted per cycle unless the output stalls; each item passes through the
// input register and then the result register, which drives m_axis.
// All timer lanes update in parallel in the single stage between the input and
// result registers. Reset clears all timers to expired and tick_shift to zero.
// A stalled output holds the input register, and the input stalls only when
// both registers are full.
module multi_timer_pool #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mtp_pkg::ShiftW-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,   // timer_id, duration_ms
  input  logic [1:0]                 s_axis_tuser,   // operation
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata    // addressed_expired, expired_mask
);
  import mtp_pkg::*;

  logic [ShiftW-1:0] tick_shift_q;
  item_t             item_q;
  logic              in_valid_q;
  result_t           res_q;
  result_t           res_c;
  logic              out_valid_q;
  logic              advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_shift_q <= '0;
    end else if (cfg_we_i) begin
      tick_shift_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.operation   <= op_e'(s_axis_tuser);
      item_q.timer_id    <= s_axis_tdata[IdW-1:0];
      item_q.duration_ms <= s_axis_tdata[IdW+DurW-1:IdW];
    end
  end

  mtp_timer_bank #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (item_q),
    .tick_shift_i(tick_shift_q),
    .result_o    (res_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.expired_mask, res_q.addressed_expired};

endmodule

/* bench/tb_multi_timer_pool.sv */
`timescale 1ns / 1ps

module tb_multi_timer_pool;
  import mtp_pkg::*;

  localparam int unsigned Timers     = 16;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned PlanLen    = 25;
  localparam int unsigned PhaseItems = 200;

  typedef struct packed {
    logic             load_shift;
    op_e              op;
    logic [IdW-1:0]   id;
    logic [DurW-1:0]  ms;
    logic             known;
    logic             done;
    logic [MaskW-1:0] mask;
  } plan_row_t;

  typedef struct packed {
    logic    known;
    result_t value;
  } pinned_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ShiftW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic [23:0]       m_axis_tdata;

  logic [TickW-1:0]  ticks_left [Timers];
  logic              armed [Timers];
  logic [ShiftW-1:0] shift_model;

  result_t           expected_q [$];
  pinned_t           pinned_q [$];
  plan_row_t         plan [PlanLen];

  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned ready_left = 0;
  int unsigned items_sent = 0;
  int unsigned ticks_seen = 0;
  int unsigned expirations = 0;
  int unsigned results_checked = 0;
  bit          idle_on = 1'b1;

  multi_timer_pool dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic result_t advance_timers(op_e op, logic [IdW-1:0] id,
                                             logic [DurW-1:0] ms);
    result_t r;
    logic    any_zero;
    r = '0;
    any_zero = 1'b0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < Timers; i++) begin
          if (armed[i] && ticks_left[i] == '0) any_zero = 1'b1;
        end
        for (int i = 0; i < Timers; i++) begin
          if (armed[i]) begin
            if (!any_zero) ticks_left[i] = ticks_left[i] - TickW'(1);
            if (ticks_left[i] == '0) begin
              armed[i] = 1'b0;
              r.expired_mask[i] = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        ticks_left[id] = ms >> shift_model;
        armed[id] = (ms != '0);
      end
      OP_STOP: armed[id] = 1'b0;
      default: ;
    endcase
    r.addressed_expired = !armed[id];
    return r;
  endfunction

  // Observes both channels at each edge: predicts on input transfers and
  // checks each output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    pinned_t pin;
    if (rst_ni) begin
      if (cfg_we_i) shift_model = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        want = advance_timers(op_e'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[19:4]);
        pin = pinned_q.pop_front();
        expected_q.push_back(pin.known ? pin.value : want);
        if (op_e'(s_axis_tuser) == OP_TICK) ticks_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.addressed_expired = m_axis_tdata[0];
        seen.expired_mask = m_axis_tdata[16:1];
        expirations += $countones(seen.expired_mask);
        results_checked++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: addressed_expired=%0b expired_mask=%h",
                 seen.addressed_expired, seen.expired_mask);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (seen.addressed_expired !== want.addressed_expired) begin
            $error("addressed_expired: expected %0b, got %0b",
                   want.addressed_expired, seen.addressed_expired);
            errors++;
          end
          if (seen.expired_mask !== want.expired_mask) begin
            $error("expired_mask: expected %h, got %h", want.expired_mask, seen.expired_mask);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
      ready_left <= 0;
    end else if (ready_left == 0) begin
      m_axis_tready <= !m_axis_tready;
      ready_left <= m_axis_tready ? $urandom_range(1, 5) : $urandom_range(1, 12);
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("multi_timer_pool verification failed");
    $finish;
  end

  task automatic send_item(op_e op, logic [IdW-1:0] id, logic [DurW-1:0] ms,
                           pinned_t pin);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pinned_q.push_back(pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, ms, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic settle_and_load(logic [ShiftW-1:0] shift);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= shift;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(int unsigned shift);
    int unsigned     roll;
    op_e             op;
    logic [DurW-1:0] ms;
    roll = $urandom_range(0, 99);
    op = roll < 45 ? OP_TICK : roll < 75 ? OP_START : roll < 85 ? OP_STOP : OP_QUERY;
    if ($urandom_range(0, 9) == 0) begin
      ms = DurW'($urandom);
    end else begin
      ms = DurW'(($urandom_range(0, 24) << shift) | ($urandom & ((32'd1 << shift) - 1)));
    end
    send_item(op, IdW'($urandom_range(0, Timers - 1)), ms, '0);
  endtask

  initial begin
    int unsigned phase_shift [6];
    pinned_t     pin;

    // Short timers with zero-tick starts, long counts, stops of idle timers,
    // and the tick rule where a zero-held timer suppresses the countdown.
    plan[0]  = '{1'b0, OP_QUERY, 4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000};
    plan[1]  = '{1'b0, OP_TICK,  4'd15, 16'hFFFF, 1'b1, 1'b1, 16'h0000};
    plan[2]  = '{1'b0, OP_START, 4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000};
    plan[3]  = '{1'b0, OP_START, 4'd15, 16'hFFFF, 1'b1, 1'b0, 16'h0000};
    plan[4]  = '{1'b0, OP_START, 4'd1,  16'h0001, 1'b1, 1'b0, 16'h0000};
    plan[5]  = '{1'b0, OP_START, 4'd2,  16'h0002, 1'b1, 1'b0, 16'h0000};
    plan[6]  = '{1'b0, OP_TICK,  4'd1,  16'h0000, 1'b1, 1'b1, 16'h0002};
    plan[7]  = '{1'b0, OP_STOP,  4'd2,  16'hFFFF, 1'b1, 1'b1, 16'h0000};
    plan[8]  = '{1'b0, OP_STOP,  4'd2,  16'h0000, 1'b1, 1'b1, 16'h0000};
    plan[9]  = '{1'b0, OP_QUERY, 4'd15, 16'hFFFF, 1'b1, 1'b0, 16'h0000};
    plan[10] = '{1'b0, OP_START, 4'd5,  16'h0003, 1'b1, 1'b0, 16'h0000};
    plan[11] = '{1'b0, OP_TICK,  4'd5,  16'h0000, 1'b0, 1'b0, 16'h0000};
    plan[12] = '{1'b1, OP_QUERY, 4'd0,  16'h000F, 1'b0, 1'b0, 16'h0000};
    plan[13] = '{1'b0, OP_START, 4'd3,  16'h7FFF, 1'b1, 1'b0, 16'h0000};
    plan[14] = '{1'b0, OP_START, 4'd4,  16'hFFFF, 1'b1, 1'b0, 16'h0000};
    plan[15] = '{1'b0, OP_TICK,  4'd3,  16'h0000, 1'b1, 1'b1, 16'h0008};
    plan[16] = '{1'b0, OP_TICK,  4'd4,  16'h0000, 1'b0, 1'b0, 16'h0000};
    plan[17] = '{1'b0, OP_TICK,  4'd5,  16'h0000, 1'b0, 1'b0, 16'h0000};
    plan[18] = '{1'b0, OP_START, 4'd6,  16'h8000, 1'b1, 1'b0, 16'h0000};
    plan[19] = '{1'b0, OP_QUERY, 4'd6,  16'h0000, 1'b0, 1'b0, 16'h0000};
    plan[20] = '{1'b1, OP_QUERY, 4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000};
    plan[21] = '{1'b0, OP_STOP,  4'd15, 16'h0000, 1'b1, 1'b1, 16'h0000};
    plan[22] = '{1'b0, OP_START, 4'd7,  16'hFFFF, 1'b1, 1'b0, 16'h0000};
    plan[23] = '{1'b0, OP_TICK,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000};
    plan[24] = '{1'b0, OP_QUERY, 4'd7,  16'h0000, 1'b0, 1'b0, 16'h0000};
    phase_shift = '{3, 0, 15, 1, 9, 6};

    for (int i = 0; i < Timers; i++) begin
      ticks_left[i] = '0;
      armed[i] = 1'b0;
    end
    shift_model = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PlanLen; r++) begin
      if (plan[r].load_shift) begin
        settle_and_load(plan[r].ms[ShiftW-1:0]);
      end else begin
        pin.known = plan[r].known;
        pin.value.addressed_expired = plan[r].done;
        pin.value.expired_mask = plan[r].mask;
        send_item(plan[r].op, plan[r].id, plan[r].ms, pin);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle_and_load(ShiftW'(phase_shift[p]));
      idle_on = (p != 2);
      for (int n = 0; n < PhaseItems; n++) send_random(phase_shift[p]);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d items (%0d ticks) over shifts 0 to 15; checked %0d results.",
             items_sent, ticks_seen, results_checked);
    $display("Timers seen expiring on ticks: %0d.", expirations);
    if (errors == 0) begin
      $display("multi_timer_pool verification clean");
    end else begin
      $display("multi_timer_pool verification failed");
    end
    $finish;
  end

endmodule
